/* rtl/epi_pkg.sv */
package epi_pkg;

   localparam int unsigned EnergyWidth  = 20;
   localparam int unsigned PenaltyWidth = 13;
   localparam int unsigned ScaleWidth   = 16;
   localparam int unsigned ProductWidth = EnergyWidth + ScaleWidth;
   localparam int unsigned NormShift    = 22;
   localparam int unsigned NormWidth    = ProductWidth - NormShift;
   localparam int unsigned FracBits     = 5;
   localparam int unsigned SegWidth     = 6;
   localparam int unsigned Segments     = 32;
   localparam int unsigned DiffWidth    = 9;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [ScaleWidth-1:0]   EnergyScale = 16'd59652;
   localparam logic [FracBits-1:0]     FracMax     = 5'h1F;
   localparam logic [SegWidth-1:0]     SegLast     = 6'd31;
   localparam logic [PenaltyWidth-1:0] PenaltyMin  = 13'd1024;
   localparam logic [PenaltyWidth-1:0] PenaltyMax  = 13'd7566;

   localparam logic [CsrIndexWidth-1:0] CsrFullEnergy  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrEmptyEnergy = 2'd1;

   localparam logic [EnergyWidth-1:0] FullEnergyReset  = 20'd72000;
   localparam logic [EnergyWidth-1:0] EmptyEnergyReset = 20'd0;

   typedef logic [PenaltyWidth-1:0] penalty_rom_type [0:Segments];

   localparam penalty_rom_type PenaltyRom = '{
      13'd1024, 13'd1090, 13'd1161, 13'd1236, 13'd1316, 13'd1401, 13'd1491, 13'd1588,
      13'd1689, 13'd1799, 13'd1915, 13'd2038, 13'd2170, 13'd2311, 13'd2460, 13'd2620,
      13'd2783, 13'd2963, 13'd3154, 13'd3358, 13'd3575, 13'd3806, 13'd4052, 13'd4314,
      13'd4593, 13'd4890, 13'd5206, 13'd5543, 13'd5901, 13'd6283, 13'd6689, 13'd7122,
      13'd7566
   };

   typedef struct packed {
      logic                 valid;
      logic                 full;
      logic                 empty;
      logic [NormWidth-1:0] norm;
   } epi_norm_type;

endpackage

/* rtl/energy_penalty_interpolator.sv */
// Energy penalty interpolator: maps a stored-energy reading to a penalty
// factor (1024 = one) by linear interpolation in a 33-entry table. A
// transaction is taken whenever start is high; busy is never raised, so one
// reading can be given every clock cycle. The result appears on rsp_penalty
// with rsp_valid high for exactly one cycle, after the registered stages of
// threshold compare, 20x16 multiply, table read and interpolation.
// Results cannot be held off and must be captured when rsp_valid is high.
// The user must write threshold registers through the csr_ port only while
// no transaction is in flight; the block itself does not enforce this.
module energy_penalty_interpolator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [epi_pkg::EnergyWidth-1:0]      req_energy_surplus,
   output logic                                 rsp_valid,
   output logic [epi_pkg::PenaltyWidth-1:0]     rsp_penalty,
   input  logic                                 csr_write_enable,
   input  logic [epi_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [epi_pkg::EnergyWidth-1:0]      csr_write_data
);
   import epi_pkg::*;

   logic [EnergyWidth-1:0]  full_energy_ff;
   logic [EnergyWidth-1:0]  empty_energy_ff;

   logic                    s1_valid_ff;
   logic                    s1_full_ff, s1_full_in;
   logic                    s1_empty_ff, s1_empty_in;
   logic [EnergyWidth-1:0]  s1_consumed_ff, s1_consumed_in;

   logic [ProductWidth-1:0] product;
   epi_norm_type            s2_ff, s2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_energy_ff  <= FullEnergyReset;
         empty_energy_ff <= EmptyEnergyReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrFullEnergy:  full_energy_ff  <= csr_write_data;
            CsrEmptyEnergy: empty_energy_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // threshold compare and consumed energy
   always_comb begin
      s1_full_in     = req_energy_surplus >= full_energy_ff;
      s1_empty_in    = req_energy_surplus <= empty_energy_ff;
      s1_consumed_in = full_energy_ff - req_energy_surplus;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_full_ff     <= s1_full_in;
      s1_empty_ff    <= s1_empty_in;
      s1_consumed_ff <= s1_consumed_in;
   end

   // full-width scale, no wrap
   always_comb begin
      product     = ProductWidth'(s1_consumed_ff) * ProductWidth'(EnergyScale);
      s2_in.valid = s1_valid_ff;
      s2_in.full  = s1_full_ff;
      s2_in.empty = s1_empty_ff;
      s2_in.norm  = product[ProductWidth-1:NormShift];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= s2_in.valid;
      end
      s2_ff.full  <= s2_in.full;
      s2_ff.empty <= s2_in.empty;
      s2_ff.norm  <= s2_in.norm;
   end

   epi_interp u_interp (
      .clock       (clock),
      .reset       (reset),
      .norm_in     (s2_ff),
      .rsp_valid   (rsp_valid),
      .rsp_penalty (rsp_penalty)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##4 rsp_valid)
      else $error("transaction result did not appear after four cycles");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      s2_ff.valid |-> $past(start, 2))
      else $error("pipeline valid without an accepted transaction");

   a_penalty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_penalty >= PenaltyMin && rsp_penalty <= PenaltyMax)
      else $error("penalty outside table range");

endmodule

/* rtl/epi_interp.sv */
module epi_interp (
   input  logic                               clock,
   input  logic                               reset,
   input  epi_pkg::epi_norm_type              norm_in,
   output logic                               rsp_valid,
   output logic [epi_pkg::PenaltyWidth-1:0]   rsp_penalty
);
   import epi_pkg::*;

   logic [NormWidth-FracBits-1:0] seg_raw;
   logic [SegWidth-1:0]           seg;
   logic [FracBits-1:0]           frac;
   logic [PenaltyWidth-1:0]       rom_lo;
   logic [PenaltyWidth-1:0]       rom_hi;

   logic                          s3_valid_ff, s3_valid_in;
   logic [PenaltyWidth-1:0]       s3_lo_ff, s3_lo_in;
   logic [DiffWidth-1:0]          s3_diff_ff, s3_diff_in;
   logic [FracBits-1:0]           s3_frac_ff, s3_frac_in;

   logic                          out_valid_ff;
   logic [PenaltyWidth-1:0]       out_penalty_ff, out_penalty_in;
   logic [DiffWidth+FracBits-1:0] step;

   // segment select with clamp past the table
   always_comb begin
      seg_raw = norm_in.norm[NormWidth-1:FracBits];
      if (seg_raw >= (NormWidth-FracBits)'(Segments)) begin
         seg  = SegLast;
         frac = FracMax;
      end else begin
         seg  = seg_raw[SegWidth-1:0];
         frac = norm_in.norm[FracBits-1:0];
      end
      rom_lo = PenaltyRom[seg];
      rom_hi = PenaltyRom[seg + SegWidth'(1)];
   end

   always_comb begin
      s3_valid_in = norm_in.valid;
      s3_frac_in  = frac;
      if (norm_in.full) begin
         s3_lo_in   = PenaltyMin;
         s3_diff_in = '0;
      end else if (norm_in.empty) begin
         s3_lo_in   = PenaltyMax;
         s3_diff_in = '0;
      end else begin
         s3_lo_in   = rom_lo;
         s3_diff_in = DiffWidth'(rom_hi - rom_lo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
      s3_lo_ff   <= s3_lo_in;
      s3_diff_ff <= s3_diff_in;
      s3_frac_ff <= s3_frac_in;
   end

   // linear step inside the segment
   always_comb begin
      step           = (DiffWidth+FracBits)'(s3_diff_ff) * (DiffWidth+FracBits)'(s3_frac_ff);
      out_penalty_in = s3_lo_ff + PenaltyWidth'(step >> FracBits);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s3_valid_ff;
      end
      out_penalty_ff <= out_penalty_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_penalty = out_penalty_ff;

   a_full_takes_min: assert property (@(posedge clock) disable iff (reset)
      norm_in.valid && norm_in.full |=> s3_lo_ff == PenaltyMin && s3_diff_ff == '0)
      else $error("full transaction did not select minimum penalty");

   a_empty_takes_max: assert property (@(posedge clock) disable iff (reset)
      norm_in.valid && !norm_in.full && norm_in.empty
      |=> s3_lo_ff == PenaltyMax && s3_diff_ff == '0)
      else $error("empty transaction did not select maximum penalty");

   a_valid_follows: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |=> out_valid_ff)
      else $error("transaction lost between interpolation stages");

endmodule

/* verif/energy_penalty_interpolator_tb.sv */
`timescale 1ns / 100ps

module energy_penalty_interpolator_tb;
   import epi_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CsrSpareLow  = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrSpareHigh = 2'd3;
   localparam int unsigned PipeLatency  = 4;
   localparam int unsigned StallLimit   = 500;
   localparam int unsigned MaxGap       = 17;
   localparam int unsigned RandomPhases = 6;
   localparam int unsigned PhaseItems   = 325;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [EnergyWidth-1:0]    req_energy_surplus = '0;
   logic                      rsp_valid;
   logic [PenaltyWidth-1:0]   rsp_penalty;
   logic                      csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0]  csr_index = CsrFullEnergy;
   logic [EnergyWidth-1:0]    csr_write_data = '0;

   logic [EnergyWidth-1:0]    full_threshold = FullEnergyReset;
   logic [EnergyWidth-1:0]    empty_threshold = EmptyEnergyReset;
   logic [PenaltyWidth-1:0]   expected_penalties [$];
   int unsigned               mismatch_count = 0;
   int unsigned               stall_cycles = 0;
   bit                        back_to_back = 1'b0;

   energy_penalty_interpolator dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_energy_surplus (req_energy_surplus),
      .rsp_valid          (rsp_valid),
      .rsp_penalty        (rsp_penalty),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [PenaltyWidth-1:0] predict_penalty(
      input logic [EnergyWidth-1:0] surplus
   );
      logic [ProductWidth-1:0]          product;
      logic [NormWidth-1:0]             norm;
      logic [NormWidth-FracBits-1:0]    seg;
      logic [FracBits-1:0]              frac;
      logic [PenaltyWidth-1:0]          lo;
      logic [PenaltyWidth-1:0]          hi;
      logic [PenaltyWidth+FracBits-1:0] slope;
      if (surplus >= full_threshold)
         return PenaltyRom[0];
      if (surplus <= empty_threshold)
         return PenaltyRom[Segments];
      product = ProductWidth'(full_threshold - surplus) * ProductWidth'(EnergyScale);
      norm = product[ProductWidth-1:NormShift];
      seg = norm[NormWidth-1:FracBits];
      frac = norm[FracBits-1:0];
      // beyond the last segment: pin to the top of segment 31
      if (seg >= Segments) begin
         seg = (NormWidth-FracBits)'(SegLast);
         frac = FracMax;
      end
      lo = PenaltyRom[seg];
      hi = PenaltyRom[seg + 1];
      slope = (PenaltyWidth+FracBits)'(hi - lo) * (PenaltyWidth+FracBits)'(frac);
      return lo + PenaltyWidth'(slope >> FracBits);
   endfunction

   // record each accepted transaction and check each result
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            expected_penalties.push_back(predict_penalty(req_energy_surplus));
         if (rsp_valid) begin
            if (expected_penalties.size() == 0) begin
               $error("penalty: no transaction outstanding, actual %0d", rsp_penalty);
               mismatch_count++;
            end else begin
               logic [PenaltyWidth-1:0] want;
               want = expected_penalties.pop_front();
               if (rsp_penalty !== want) begin
                  $error("penalty: expected %0d, actual %0d", want, rsp_penalty);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_surplus(input logic [EnergyWidth-1:0] surplus);
      int unsigned gap;
      gap = back_to_back ? 0 : $urandom_range(0, MaxGap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_energy_surplus <= surplus;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (expected_penalties.size() != 0)
         @(negedge clock);
      repeat (PipeLatency) @(negedge clock);
   endtask

   task automatic write_csr(
      input logic [CsrIndexWidth-1:0] index,
      input logic [EnergyWidth-1:0]   value
   );
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      case (index)
         CsrFullEnergy:  full_threshold = value;
         CsrEmptyEnergy: empty_threshold = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [EnergyWidth-1:0] draw_surplus();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0 || full_threshold <= empty_threshold + 1)
         return EnergyWidth'($urandom);
      if (pick == 1)
         return full_threshold - EnergyWidth'($urandom_range(0, 1));
      if (pick == 2)
         return empty_threshold + EnergyWidth'($urandom_range(0, 1));
      return EnergyWidth'($urandom_range(full_threshold - 1, empty_threshold + 1));
   endfunction

   task automatic test_reset_defaults();
      // thresholds straight out of reset
      send_surplus('0);
      send_surplus(20'd1);
      send_surplus(20'd71999);
      send_surplus(20'd72000);
      send_surplus(20'd72001);
      send_surplus('1);
      send_surplus(20'd36000);
      send_surplus(20'd70);
      send_surplus(20'd69891);
   endtask

   task automatic test_threshold_extremes();
      write_csr(CsrFullEnergy, '1);
      write_csr(CsrEmptyEnergy, '0);
      send_surplus('0);
      send_surplus(20'd1);
      send_surplus(20'd524288);
      send_surplus(20'hFFFFE);
      send_surplus('1);
      write_csr(CsrFullEnergy, 20'd1);
      send_surplus('0);
      send_surplus(20'd1);
      // zero full threshold: everything reads as full
      write_csr(CsrFullEnergy, '0);
      send_surplus('0);
      send_surplus(20'd5);
   endtask

   task automatic test_crossed_thresholds();
      write_csr(CsrFullEnergy, 20'd1000);
      write_csr(CsrEmptyEnergy, 20'd5000);
      send_surplus(20'd999);
      send_surplus(20'd1000);
      send_surplus(20'd3000);
   endtask

   task automatic test_spare_index();
      write_csr(CsrEmptyEnergy, 20'd100);
      write_csr(CsrFullEnergy, 20'd90000);
      write_csr(CsrSpareLow, '1);
      write_csr(CsrSpareHigh, 20'h5A5A5);
      send_surplus(20'd50000);
      send_surplus(20'd100);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0: begin
               write_csr(CsrFullEnergy, FullEnergyReset);
               write_csr(CsrEmptyEnergy, EmptyEnergyReset);
            end
            1: begin
               write_csr(CsrFullEnergy, '1);
               write_csr(CsrEmptyEnergy, '0);
            end
            default: begin
               write_csr(CsrFullEnergy, EnergyWidth'($urandom_range(1, 20'hFFFFF)));
               if ($urandom_range(0, 3) == 0)
                  write_csr(CsrEmptyEnergy, EnergyWidth'($urandom));
               else
                  write_csr(CsrEmptyEnergy,
                            EnergyWidth'($urandom_range(0, full_threshold - 1)));
               if ($urandom_range(0, 1) == 0)
                  write_csr($urandom_range(0, 1) ? CsrSpareLow : CsrSpareHigh,
                            EnergyWidth'($urandom));
            end
         endcase
         for (int n = 0; n < PhaseItems; n++) begin
            if (n % 40 == 0)
               back_to_back = ($urandom_range(0, 2) == 0);
            send_surplus(draw_surplus());
         end
         back_to_back = 1'b0;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_threshold_extremes();
      test_crossed_thresholds();
      test_spare_index();
      test_random_traffic();
      wait_idle();
      if (expected_penalties.size() != 0) begin
         $error("penalty: %0d transactions without a result", expected_penalties.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
rtl/epi_pkg.sv
rtl/epi_interp.sv
rtl/energy_penalty_interpolator.sv
verif/energy_penalty_interpolator_tb.sv
